// ===== design/prc_pkg.sv =====
// shared types and constants for the polygon rectangle clipper
package prc_pkg;

    localparam int CW  = 16;
    localparam int DW  = CW + 1;
    localparam int PW  = 2 * DW;
    localparam int TDW = ((2 * CW + 7) / 8) * 8;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [DW-1:0] diff_t;
    typedef logic signed [PW-1:0] prod_t;

    localparam logic [1:0] STG_LEFT   = 2'd0;
    localparam logic [1:0] STG_RIGHT  = 2'd1;
    localparam logic [1:0] STG_TOP    = 2'd2;
    localparam logic [1:0] STG_BOTTOM = 2'd3;

    localparam logic [2:0] LVL_SINK = 3'd4;

    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_BOTTOM = 2'd1;
    localparam logic [1:0] REG_RIGHT  = 2'd2;
    localparam logic [1:0] REG_TOP    = 2'd3;

    typedef struct packed {
        coord_t a0;
        coord_t a1;
        coord_t o0;
        coord_t o1;
        coord_t b;
    } xreq_t;

endpackage

// ===== design/prc_xing.sv =====
// crossing point unit: one multiply then a bit-serial restoring divide
module prc_xing
    import prc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  xreq_t  req,
    output logic   done,
    output coord_t res
);

    localparam int CNTW = $clog2(PW + 1);

    typedef enum logic [1:0] {X_IDLE, X_MUL, X_DIV, X_FIN} xstate_t;

    xstate_t          state_reg;
    diff_t            n_reg;
    diff_t            m_reg;
    diff_t            d_reg;
    coord_t           o0_reg;
    logic [DW-1:0]    dmag_reg;
    logic             neg_reg;
    logic [DW:0]      rem_reg;
    logic [PW-1:0]    quo_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic             done_reg;
    coord_t           res_reg;

    prod_t            prod;
    logic [DW:0]      trial;
    logic             fits;
    logic [PW-1:0]    qs;

    assign prod  = n_reg * m_reg;
    assign trial = {rem_reg[DW-1:0], quo_reg[PW-1]};
    assign fits  = trial >= {1'b0, dmag_reg};
    assign qs    = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= X_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == X_FIN);
            case (state_reg)
                X_IDLE:
                begin
                    if (start)
                    begin
                        n_reg     <= DW'(req.o1) - DW'(req.o0);
                        m_reg     <= DW'(req.b) - DW'(req.a0);
                        d_reg     <= DW'(req.a1) - DW'(req.a0);
                        o0_reg    <= req.o0;
                        state_reg <= X_MUL;
                    end
                end
                X_MUL:
                begin
                    neg_reg   <= prod[PW-1] ^ d_reg[DW-1];
                    quo_reg   <= prod[PW-1] ? PW'(-prod) : PW'(prod);
                    dmag_reg  <= d_reg[DW-1] ? DW'(-d_reg) : DW'(d_reg);
                    rem_reg   <= '0;
                    cnt_reg   <= CNTW'(PW);
                    state_reg <= X_DIV;
                end
                X_DIV:
                begin
                    rem_reg   <= fits ? (trial - {1'b0, dmag_reg}) : trial;
                    quo_reg   <= {quo_reg[PW-2:0], fits};
                    cnt_reg   <= cnt_reg - 1'b1;
                    if (cnt_reg == CNTW'(1))
                        state_reg <= X_FIN;
                end
                X_FIN:
                begin
                    res_reg   <= (dmag_reg == '0) ? o0_reg : (o0_reg + coord_t'(qs[CW-1:0]));
                    state_reg <= X_IDLE;
                end
                default: state_reg <= X_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// ===== design/polygon_rect_clipper_top.sv =====
// top level of the polygon rectangle clipper: config registers and stage sequencer
// Takes polygon vertices one transfer at a time and returns the polygon clipped
// against the window (left, bottom, right, top, inclusive), running the left,
// right, top and bottom clip stages in turn under one sequencer. Each boundary
// crossing goes through the shared multiply and one-bit-a-cycle divide unit,
// and the new point is then carried on. A vertex marked last also closes every
// stage, each of which may add a crossing on its closing edge. A result waiting
// on a stalled output holds the sequencer. Results lag one vertex so the final
// one carries tlast; a fully clipped polygon gives one result with tuser low.
// The input is not ready while a vertex is in work.
module polygon_rect_clipper_top
    import prc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [TDW-1:0] s_axis_tdata,  // vert_x, vert_y
    input  logic           s_axis_tlast,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [TDW-1:0] m_axis_tdata,  // out_x, out_y
    output logic           m_axis_tuser,  // out_valid
    output logic           m_axis_tlast,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    typedef enum logic [2:0] {S_IDLE, S_STAGE, S_XWAIT, S_POP, S_CLOSE} state_t;

    state_t       state_reg;
    coord_t       win_l_reg, win_b_reg, win_r_reg, win_t_reg;
    coord_t       first_x_reg [4];
    coord_t       first_y_reg [4];
    coord_t       prev_x_reg  [4];
    coord_t       prev_y_reg  [4];
    logic [3:0]   started_reg;
    logic [3:0]   pend_v_reg;
    coord_t       pend_x_reg  [4];
    coord_t       pend_y_reg  [4];
    logic [2:0]   cur_reg;
    logic [2:0]   clv_reg;
    logic [1:0]   xlvl_reg;
    coord_t       cx_reg, cy_reg;
    logic         last_reg;
    logic         closing_reg;
    logic         any_reg;
    coord_t       hold_x_reg, hold_y_reg;
    logic         out_tv_reg;
    coord_t       out_x_reg, out_y_reg;
    logic         out_v_reg, out_l_reg;
    logic         xstart_reg;
    xreq_t        xreq_reg;

    logic         xdone;
    coord_t       xres;
    logic         out_free;
    logic [1:0]   s;
    logic [1:0]   cs;
    logic         pin, pprev, cprev, cfirst;
    logic         pop_found;
    logic [1:0]   pop_k;
    logic         wr;
    logic         x_go;
    logic         out_load;

    function automatic logic inside_f(input logic [1:0] st, input coord_t x, input coord_t y,
                                      input coord_t l, input coord_t r,
                                      input coord_t t, input coord_t b);
        logic v;
        case (st)
            STG_LEFT:  v = x >= l;
            STG_RIGHT: v = x <= r;
            STG_TOP:   v = y <= t;
            default:   v = y >= b;
        endcase
        return v;
    endfunction

    function automatic xreq_t mk_req(input logic [1:0] st, input coord_t sx, input coord_t sy,
                                     input coord_t px, input coord_t py,
                                     input coord_t l, input coord_t r,
                                     input coord_t t, input coord_t b);
        xreq_t q;
        if (st == STG_LEFT || st == STG_RIGHT)
        begin
            q.a0 = sx; q.a1 = px; q.o0 = sy; q.o1 = py;
            q.b  = (st == STG_LEFT) ? l : r;
        end
        else
        begin
            q.a0 = sy; q.a1 = py; q.o0 = sx; q.o1 = px;
            q.b  = (st == STG_TOP) ? t : b;
        end
        return q;
    endfunction

    prc_xing u_xing
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (xstart_reg),
        .req   (xreq_reg),
        .done  (xdone),
        .res   (xres)
    );

    assign s        = cur_reg[1:0];
    assign cs       = clv_reg[1:0];
    assign pin      = inside_f(s, cx_reg, cy_reg, win_l_reg, win_r_reg, win_t_reg, win_b_reg);
    assign pprev    = inside_f(s, prev_x_reg[s], prev_y_reg[s],
                               win_l_reg, win_r_reg, win_t_reg, win_b_reg);
    assign cprev    = inside_f(cs, prev_x_reg[cs], prev_y_reg[cs],
                               win_l_reg, win_r_reg, win_t_reg, win_b_reg);
    assign cfirst   = inside_f(cs, first_x_reg[cs], first_y_reg[cs],
                               win_l_reg, win_r_reg, win_t_reg, win_b_reg);
    assign out_free = !out_tv_reg || m_axis_tready;
    assign wr       = psel && penable && pwrite;

    // crossing requests and output loads
    assign x_go     = ((state_reg == S_STAGE) && (cur_reg != LVL_SINK) &&
                       started_reg[s] && (pprev != pin)) ||
                      ((state_reg == S_CLOSE) && (clv_reg != LVL_SINK) &&
                       started_reg[cs] && (cprev != cfirst));
    assign out_load = ((state_reg == S_STAGE) && (cur_reg == LVL_SINK) && any_reg && out_free) ||
                      ((state_reg == S_CLOSE) && (clv_reg == LVL_SINK) && out_free);

    always_comb
    begin
        pop_found = 1'b0;
        pop_k     = 2'd0;
        for (int k = 0; k < 4; k++)
        begin
            if (pend_v_reg[k])
            begin
                pop_found = 1'b1;
                pop_k     = 2'(k);
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_l_reg <= coord_t'(0);
            win_b_reg <= coord_t'(0);
            win_r_reg <= coord_t'(255);
            win_t_reg <= coord_t'(255);
        end
        else if (wr)
        begin
            case (paddr[3:2])
                REG_LEFT:   win_l_reg <= pwdata[CW-1:0];
                REG_BOTTOM: win_b_reg <= pwdata[CW-1:0];
                REG_RIGHT:  win_r_reg <= pwdata[CW-1:0];
                default:    win_t_reg <= pwdata[CW-1:0];
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_LEFT:   prdata = 32'(win_l_reg);
            REG_BOTTOM: prdata = 32'(win_b_reg);
            REG_RIGHT:  prdata = 32'(win_r_reg);
            default:    prdata = 32'(win_t_reg);
        endcase
    end
    assign pready = 1'b1;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            started_reg <= '0;
            pend_v_reg  <= '0;
            any_reg     <= 1'b0;
            closing_reg <= 1'b0;
            last_reg    <= 1'b0;
            out_tv_reg  <= 1'b0;
            xstart_reg  <= 1'b0;
            cur_reg     <= '0;
            clv_reg     <= '0;
            for (int k = 0; k < 4; k++)
            begin
                first_x_reg[k] <= '0;
                first_y_reg[k] <= '0;
                prev_x_reg[k]  <= '0;
                prev_y_reg[k]  <= '0;
            end
            hold_x_reg  <= '0;
            hold_y_reg  <= '0;
        end
        else
        begin
            xstart_reg <= x_go;
            if (out_load)
                out_tv_reg <= 1'b1;
            else if (m_axis_tready)
                out_tv_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        cx_reg    <= s_axis_tdata[CW-1:0];
                        cy_reg    <= s_axis_tdata[2*CW-1:CW];
                        last_reg  <= s_axis_tlast;
                        cur_reg   <= 3'd0;
                        state_reg <= S_STAGE;
                    end
                end
                S_STAGE:
                begin
                    if (cur_reg == LVL_SINK)
                    begin
                        if (!any_reg || out_free)
                        begin
                            if (any_reg)
                            begin
                                out_x_reg  <= hold_x_reg;
                                out_y_reg  <= hold_y_reg;
                                out_v_reg  <= 1'b1;
                                out_l_reg  <= 1'b0;
                            end
                            hold_x_reg <= cx_reg;
                            hold_y_reg <= cy_reg;
                            any_reg    <= 1'b1;
                            state_reg  <= S_POP;
                        end
                    end
                    else
                    begin
                        prev_x_reg[s] <= cx_reg;
                        prev_y_reg[s] <= cy_reg;
                        if (!started_reg[s])
                        begin
                            first_x_reg[s] <= cx_reg;
                            first_y_reg[s] <= cy_reg;
                            started_reg[s] <= 1'b1;
                            if (pin)
                                cur_reg <= cur_reg + 1'b1;
                            else
                                state_reg <= S_POP;
                        end
                        else if (pprev != pin)
                        begin
                            xreq_reg      <= mk_req(s, prev_x_reg[s], prev_y_reg[s], cx_reg, cy_reg,
                                                    win_l_reg, win_r_reg, win_t_reg, win_b_reg);
                            xlvl_reg      <= s;
                            pend_v_reg[s] <= pin;
                            pend_x_reg[s] <= cx_reg;
                            pend_y_reg[s] <= cy_reg;
                            state_reg     <= S_XWAIT;
                        end
                        else if (pin)
                            cur_reg <= cur_reg + 1'b1;
                        else
                            state_reg <= S_POP;
                    end
                end
                S_XWAIT:
                begin
                    if (xdone)
                    begin
                        if (xlvl_reg == STG_LEFT)
                        begin
                            cx_reg <= win_l_reg; cy_reg <= xres;
                        end
                        else if (xlvl_reg == STG_RIGHT)
                        begin
                            cx_reg <= win_r_reg; cy_reg <= xres;
                        end
                        else if (xlvl_reg == STG_TOP)
                        begin
                            cx_reg <= xres; cy_reg <= win_t_reg;
                        end
                        else
                        begin
                            cx_reg <= xres; cy_reg <= win_b_reg;
                        end
                        cur_reg   <= {1'b0, xlvl_reg} + 3'd1;
                        state_reg <= S_STAGE;
                    end
                end
                S_POP:
                begin
                    if (pop_found)
                    begin
                        pend_v_reg[pop_k] <= 1'b0;
                        cx_reg            <= pend_x_reg[pop_k];
                        cy_reg            <= pend_y_reg[pop_k];
                        cur_reg           <= {1'b0, pop_k} + 3'd1;
                        state_reg         <= S_STAGE;
                    end
                    else if (!last_reg)
                        state_reg <= S_IDLE;
                    else if (!closing_reg)
                    begin
                        closing_reg <= 1'b1;
                        clv_reg     <= 3'd0;
                        state_reg   <= S_CLOSE;
                    end
                    else
                    begin
                        clv_reg   <= clv_reg + 1'b1;
                        state_reg <= S_CLOSE;
                    end
                end
                S_CLOSE:
                begin
                    if (clv_reg == LVL_SINK)
                    begin
                        if (out_free)
                        begin
                            out_x_reg   <= any_reg ? hold_x_reg : coord_t'(0);
                            out_y_reg   <= any_reg ? hold_y_reg : coord_t'(0);
                            out_v_reg   <= any_reg;
                            out_l_reg   <= 1'b1;
                            any_reg     <= 1'b0;
                            closing_reg <= 1'b0;
                            last_reg    <= 1'b0;
                            state_reg   <= S_IDLE;
                        end
                    end
                    else if (started_reg[cs])
                    begin
                        started_reg[cs] <= 1'b0;
                        if (cprev != cfirst)
                        begin
                            xreq_reg   <= mk_req(cs, prev_x_reg[cs], prev_y_reg[cs],
                                                 first_x_reg[cs], first_y_reg[cs],
                                                 win_l_reg, win_r_reg, win_t_reg, win_b_reg);
                            xlvl_reg   <= cs;
                            state_reg  <= S_XWAIT;
                        end
                        else
                            clv_reg <= clv_reg + 1'b1;
                    end
                    else
                        clv_reg <= clv_reg + 1'b1;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_tv_reg;
    assign m_axis_tdata  = TDW'({out_y_reg, out_x_reg});
    assign m_axis_tuser  = out_v_reg;
    assign m_axis_tlast  = out_l_reg;

endmodule

// ===== tb/tb_polygon_rect_clipper_top.sv =====
// testbench for the polygon rectangle clipper: directed and random polygons checked against a predictor
module tb_polygon_rect_clipper_top;
    import prc_pkg::*;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   valid;
        logic   last;
    } clip_vtx_t;

    typedef struct {
        coord_t x;
        coord_t y;
        logic   last;
        logic   chk;
        clip_vtx_t r0;
    } vrow_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    polygon_rect_clipper_top dut (.*);

    // window copy and per-stage state
    longint w_left, w_bottom, w_right, w_top;
    longint st_fx [4];
    longint st_fy [4];
    longint st_px [4];
    longint st_py [4];
    bit     st_on [4];
    bit     held_ok;
    longint held_x, held_y;

    clip_vtx_t clip_q[$];
    int  errors = 0;
    longint cycles = 0;
    int  stall_n = 0;

    initial
        clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint sx16(longint v);
        logic signed [15:0] t;
        t = v[15:0];
        return longint'(t);
    endfunction

    function automatic bit in_window(int s, longint x, longint y);
        case (s)
            0: return x >= w_left;
            1: return x <= w_right;
            2: return y <= w_top;
            default: return y >= w_bottom;
        endcase
    endfunction

    function automatic void emit_clip(longint x, longint y, bit valid, bit last);
        clip_vtx_t e;
        e.x = x[15:0];
        e.y = y[15:0];
        e.valid = valid;
        e.last = last;
        clip_q = {clip_q, e};
    endfunction

    function automatic void sink_vtx(longint x, longint y);
        if (held_ok)
            emit_clip(held_x, held_y, 1'b1, 1'b0);
        held_x = x;
        held_y = y;
        held_ok = 1'b1;
    endfunction

    function automatic void push_stage(int s, longint x, longint y);
        bit pin;
        longint b, a0, a1, o0, o1, o;
        if (s >= 4)
        begin
            sink_vtx(x, y);
            return;
        end
        pin = in_window(s, x, y);
        if (!st_on[s])
        begin
            st_fx[s] = x;
            st_fy[s] = y;
            st_on[s] = 1'b1;
        end
        else if (in_window(s, st_px[s], st_py[s]) != pin)
        begin
            b  = (s == 0) ? w_left : (s == 1) ? w_right : (s == 2) ? w_top : w_bottom;
            a0 = (s < 2) ? st_px[s] : st_py[s];
            a1 = (s < 2) ? x : y;
            o0 = (s < 2) ? st_py[s] : st_px[s];
            o1 = (s < 2) ? y : x;
            o  = (a1 == a0) ? o0 : sx16(o0 + ((o1 - o0) * (b - a0)) / (a1 - a0));
            if (s < 2)
                push_stage(s + 1, b, o);
            else
                push_stage(s + 1, o, b);
        end
        st_px[s] = x;
        st_py[s] = y;
        if (pin)
            push_stage(s + 1, x, y);
    endfunction

    function automatic void close_stage(int s);
        longint b, a0, a1, o0, o1, o;
        if (s >= 4)
        begin
            if (held_ok)
                emit_clip(held_x, held_y, 1'b1, 1'b1);
            else
                emit_clip(0, 0, 1'b0, 1'b1);
            held_ok = 1'b0;
            return;
        end
        if (st_on[s])
        begin
            if (in_window(s, st_px[s], st_py[s]) != in_window(s, st_fx[s], st_fy[s]))
            begin
                b  = (s == 0) ? w_left : (s == 1) ? w_right : (s == 2) ? w_top : w_bottom;
                a0 = (s < 2) ? st_px[s] : st_py[s];
                a1 = (s < 2) ? st_fx[s] : st_fy[s];
                o0 = (s < 2) ? st_py[s] : st_px[s];
                o1 = (s < 2) ? st_fy[s] : st_fx[s];
                o  = (a1 == a0) ? o0 : sx16(o0 + ((o1 - o0) * (b - a0)) / (a1 - a0));
                if (s < 2)
                    push_stage(s + 1, b, o);
                else
                    push_stage(s + 1, o, b);
            end
            st_on[s] = 1'b0;
        end
        close_stage(s + 1);
    endfunction

    function automatic void predict_vertex(coord_t x, coord_t y, logic last);
        push_stage(0, longint'(x), longint'(y));
        if (last)
            close_stage(0);
    endfunction

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            n = 0;
        if (n > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drive_vertex(coord_t x, coord_t y, logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        idle_gap();
    endtask

    task automatic send_vertex(coord_t x, coord_t y, logic last);
        predict_vertex(x, y, last);
        drive_vertex(x, y, last);
    endtask

    task automatic write_window(logic [1:0] idx, coord_t v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{16{v[15]}}, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_LEFT:   w_left   = longint'(v);
            REG_BOTTOM: w_bottom = longint'(v);
            REG_RIGHT:  w_right  = longint'(v);
            default:    w_top    = longint'(v);
        endcase
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (clip_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_window(coord_t l, coord_t b, coord_t r, coord_t t);
        drain();
        write_window(REG_LEFT, l);
        write_window(REG_BOTTOM, b);
        write_window(REG_RIGHT, r);
        write_window(REG_TOP, t);
    endtask

    function automatic coord_t rnd_near(longint lo, longint hi);
        longint v;
        v = longint'($urandom_range(0, 32'(hi - lo + 80))) + lo - 40;
        return coord_t'(v);
    endfunction

    // sink side: stalls and checks
    always @(posedge clk)
    begin
        clip_vtx_t e;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (stall_n > 0)
            begin
                stall_n--;
                m_axis_tready <= 1'b0;
            end
            else if ($urandom_range(0, 49) == 0)
            begin
                stall_n = int'($urandom_range(10, 60));
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 9) < 7);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (clip_q.size() == 0)
                begin
                    $display("%0t unexpected transfer: actual %h user %b last %b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    errors++;
                end
                else
                begin
                    e = clip_q.pop_front();
                    if (m_axis_tdata != {e.y, e.x} || m_axis_tuser != e.valid ||
                        m_axis_tlast != e.last)
                    begin
                        $display("%0t mismatch: expected %h user %b last %b, actual %h user %b last %b",
                                 $time, {e.y, e.x}, e.valid, e.last,
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 3000000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    vrow_t rows[$];

    function automatic void add_row(coord_t x, coord_t y, logic last,
                                    logic chk, coord_t ex, coord_t ey, logic ev);
        vrow_t r;
        r.x = x; r.y = y; r.last = last; r.chk = chk;
        r.r0.x = ex; r.r0.y = ey; r.r0.valid = ev; r.r0.last = 1'b1;
        rows = {rows, r};
    endfunction

    initial
    begin
        int nsent, nv;
        coord_t ax, ay;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tlast = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        w_left = 0; w_bottom = 0; w_right = 255; w_top = 255;
        for (int i = 0; i < 4; i++)
            st_on[i] = 1'b0;
        held_ok = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single vertices with reset window, extremes, empty marker
        add_row(16'sd10, 16'sd20, 1'b1, 1'b1, 16'sd10, 16'sd20, 1'b1);
        add_row(16'sh8000, 16'sh8000, 1'b1, 1'b1, 16'sd0, 16'sd0, 1'b0);
        add_row(16'sh7fff, 16'sh7fff, 1'b1, 1'b1, 16'sd0, 16'sd0, 1'b0);
        add_row(16'sd0, 16'sd0, 1'b1, 1'b1, 16'sd0, 16'sd0, 1'b1);
        add_row(16'sd255, 16'sd255, 1'b1, 1'b1, 16'sd255, 16'sd255, 1'b1);
        // triangle crossing left and top edges
        add_row(-16'sd50, 16'sd100, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(16'sd100, 16'sd100, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(16'sd100, 16'sd400, 1'b1, 1'b0, '0, '0, 1'b0);
        // polygon wrapping the whole window
        add_row(16'sh8000, 16'sh8000, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(16'sh7fff, 16'sh8000, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(16'sh7fff, 16'sh7fff, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(16'sh8000, 16'sh7fff, 1'b1, 1'b0, '0, '0, 1'b0);
        // fully outside triangle and edges lying on boundaries
        add_row(16'sd300, 16'sd300, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(16'sd400, 16'sd300, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(16'sd400, 16'sd400, 1'b1, 1'b1, 16'sd0, 16'sd0, 1'b0);
        add_row(16'sd0, -16'sd20, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(16'sd0, 16'sd300, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(16'sd255, 16'sd300, 1'b1, 1'b0, '0, '0, 1'b0);

        foreach (rows[i])
        begin
            clip_vtx_t got;
            predict_vertex(rows[i].x, rows[i].y, rows[i].last);
            if (rows[i].chk)
            begin
                got = clip_q[clip_q.size() - 1];
                if (got != rows[i].r0)
                begin
                    $display("%0t table mismatch: expected %h actual %h",
                             $time, rows[i].r0, got);
                    errors++;
                end
            end
            drive_vertex(rows[i].x, rows[i].y, rows[i].last);
        end

        // inverted window
        set_window(16'sd100, 16'sd100, 16'sd50, 16'sd50);
        send_vertex(16'sd75, 16'sd75, 1'b0);
        send_vertex(16'sd200, 16'sd0, 1'b1);
        // full range window with extreme coordinates
        set_window(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        send_vertex(16'sh8000, 16'sh7fff, 1'b0);
        send_vertex(16'sh7fff, 16'sh8000, 1'b1);
        // narrow window near the top end of the range
        set_window(16'sh7ff0, 16'sh7ff0, 16'sh7fff, 16'sh7fff);
        send_vertex(16'sh8000, 16'sh8000, 1'b0);
        send_vertex(16'sh7fff, 16'sh7fff, 1'b0);
        send_vertex(16'sh7fff, 16'sh8000, 1'b1);

        nsent = 0;
        while (nsent < 345)
        begin
            longint l, b, r, t;
            if ($urandom_range(0, 3) == 0)
            begin
                l = $signed(16'($urandom));
                b = $signed(16'($urandom));
                r = $signed(16'($urandom));
                t = $signed(16'($urandom));
            end
            else
            begin
                l = longint'($urandom_range(0, 2000)) - 1000;
                b = longint'($urandom_range(0, 2000)) - 1000;
                r = l + longint'($urandom_range(0, 800));
                t = b + longint'($urandom_range(0, 800));
                if (r > 32767) r = 32767;
                if (t > 32767) t = 32767;
            end
            if ($urandom_range(0, 4) == 0)
                set_window(l[15:0], b[15:0], r[15:0], t[15:0]);
            l = w_left; b = w_bottom; r = w_right; t = w_top;
            if (r < l)
            begin
                l = w_right;
                r = w_left;
            end
            if (t < b)
            begin
                b = w_top;
                t = w_bottom;
            end
            nv = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
            for (int k = 0; k < nv; k++)
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    ax = coord_t'($urandom);
                    ay = coord_t'($urandom);
                end
                else
                begin
                    ax = rnd_near(l, r);
                    ay = rnd_near(b, t);
                end
                send_vertex(ax, ay, k == nv - 1);
                nsent++;
            end
        end

        drain();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
